FILE: hdl/mie_pkg.sv
// mie_pkg: shared types, codes and constants for the mips integer execute unit
// used by mie_regfile and mips_integer_execute_unit_top; depends on nothing
`default_nettype none
package mie_pkg;

    localparam int TEXT_DEPTH  = 4096;
    localparam int DATA_DEPTH  = 4096;
    localparam int STACK_DEPTH = 8192;
    localparam int TEXT_AW     = $clog2(TEXT_DEPTH);
    localparam int DATA_AW     = $clog2(DATA_DEPTH);
    localparam int STACK_AW    = $clog2(STACK_DEPTH);

    localparam logic [31:0] TEXT_BASE = 32'h0040_0000;
    localparam logic [31:0] DATA_BASE = 32'h1000_0000;
    localparam logic [31:0] STACK_TOP = 32'h7fff_ffff;

    localparam int CFG_W = 14;
    localparam logic [1:0] CFG_TEXT  = 2'd0;
    localparam logic [1:0] CFG_DATA  = 2'd1;
    localparam logic [1:0] CFG_STACK = 2'd2;

    localparam logic [2:0] ST_OK   = 3'd0;
    localparam logic [2:0] ST_OVF  = 3'd1;
    localparam logic [2:0] ST_DIVZ = 3'd2;
    localparam logic [2:0] ST_JUMP = 3'd3;
    localparam logic [2:0] ST_MEM  = 3'd4;

    typedef enum logic [5:0] {
        A_ADD, A_ADDI, A_ADDIU, A_ADDU, A_AND, A_ANDI, A_BEQ, A_BNE, A_DIV, A_DIVU,
        A_J, A_JAL, A_JALR, A_JR, A_LB, A_LBU, A_LH, A_LHU, A_LUI, A_LW,
        A_MFHI, A_MTHI, A_MFLO, A_MTLO, A_MULT, A_MULTU, A_NOR, A_XOR, A_OR, A_ORI,
        A_SB, A_SH, A_SW, A_SLT, A_SLTI, A_SLTIU, A_SLTU, A_SLL, A_SLLV, A_SRL,
        A_SRLV, A_SRA, A_SRAV, A_SUB, A_SUBU, A_PRELOAD
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE, S_OPER, S_MUL, S_DIV, S_MAP, S_MEM, S_DONE
    } t_state;

    typedef enum logic [1:0] {
        SEG_TEXT, SEG_DATA, SEG_STACK
    } t_seg;

    typedef struct packed {
        logic [5:0]         action;
        logic [4:0]         src_reg;
        logic [4:0]         tgt_reg;
        logic [4:0]         dst_reg;
        logic [4:0]         shift_amount;
        logic signed [15:0] immediate;
        logic [25:0]        jump_target;
        logic [31:0]        preload_address;
        logic [7:0]         preload_value;
    } t_in;

    typedef struct packed {
        logic [2:0]         status;
        logic               reg_written;
        logic [4:0]         written_index;
        logic signed [31:0] written_value;
        logic signed [31:0] hi_now;
        logic signed [31:0] lo_now;
        logic [31:0]        pc_now;
    } t_out;

    typedef struct packed {
        logic        we;
        logic [4:0]  idx;
        logic [31:0] data;
    } t_gpr_wr;

endpackage
`default_nettype wire

FILE: hdl/mie_byte_ram.sv
// mie_byte_ram: generic byte-wide synchronous ram, one port, registered read
// no package dependency
`default_nettype none
module mie_byte_ram #(
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [7:0]               i_wdata,
    output logic      [7:0]               o_rdata
);
    logic [7:0] mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        r_rdata <= mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

FILE: hdl/mie_regfile.sv
// mie_regfile: 32 x 32 general register memory, two registered reads, one write
// depends on mie_pkg (t_gpr_wr); entries read zero until written
`default_nettype none
module mie_regfile (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [4:0]       i_ra,
    input  wire logic [4:0]       i_rb,
    input  wire mie_pkg::t_gpr_wr i_wr,
    output logic      [31:0]      o_da,
    output logic      [31:0]      o_db
);
    logic [31:0] mem [32];
    logic [31:0] r_valid;
    logic [31:0] r_da;
    logic [31:0] r_db;
    logic        r_va;
    logic        r_vb;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            mem[i_wr.idx] <= i_wr.data;
        end
        r_da <= mem[i_ra];
        r_db <= mem[i_rb];
    end

    // valid bits stand in for the all-zero reset of the array
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_va    <= 1'b0;
            r_vb    <= 1'b0;
        end else begin
            if (i_wr.we) begin
                r_valid[i_wr.idx] <= 1'b1;
            end
            r_va <= r_valid[i_ra];
            r_vb <= r_valid[i_rb];
        end
    end

    assign o_da = r_va ? r_da : '0;
    assign o_db = r_vb ? r_db : '0;
endmodule
`default_nettype wire

FILE: hdl/mie_divider.sv
// mie_divider: unsigned 32-bit restoring divider, one quotient bit per cycle
// no package dependency; done pulses one cycle when quotient and remainder are final
`default_nettype none
module mie_divider (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_dividend,
    input  wire logic [31:0] i_divisor,
    output logic             o_done,
    output logic      [31:0] o_quotient,
    output logic      [31:0] o_remainder
);
    logic [31:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_div;
    logic [5:0]  r_cnt;
    logic        r_done;
    logic [32:0] shifted;
    logic [32:0] diff;

    assign shifted = {r_rem, r_quo[31]};
    assign diff    = shifted - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= diff[32] ? shifted[31:0] : diff[31:0];
            r_quo <= {r_quo[30:0], ~diff[32]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == 6'd1);
            if (i_start) begin
                r_cnt <= 6'd32;
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 6'd1;
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;
endmodule
`default_nettype wire

FILE: hdl/mips_integer_execute_unit_top.sv
// mips_integer_execute_unit_top: sequencer for one decoded instruction at a time
// depends on mie_pkg, mie_regfile, mie_byte_ram and mie_divider
// alu/jump/branch ops pass register read and done states; mult adds a product state,
// div/divu wait in a divide state for the divider; loads and stores check the map per
// byte, then make one byte ram access per cycle; a new transaction is taken only when idle
// reset clears registers, hi, lo; sets pc to text base and config to full segment depths; byte memories not cleared
`default_nettype none
module mips_integer_execute_unit_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire mie_pkg::t_in                i_in_data,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output mie_pkg::t_out                    o_out_data,
    input  wire logic                        i_cfg_we,
    input  wire logic [1:0]                  i_cfg_index,
    input  wire logic [mie_pkg::CFG_W-1:0]   i_cfg_wdata
);
    mie_pkg::t_state r_state, n_state;
    mie_pkg::t_in    r_item, n_item;
    mie_pkg::t_out   r_out, n_out;
    mie_pkg::t_seg   r_seg, n_seg;
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_a, n_a, r_b, n_b;
    logic [2:0]  r_status, n_status;
    logic        r_wr, n_wr;
    logic [4:0]  r_widx, n_widx;
    logic [31:0] r_wval, n_wval;
    logic [31:0] r_hi, n_hi, r_lo, n_lo, r_pc, n_pc, r_next, n_next;
    logic [63:0] r_prod, n_prod;
    logic [31:0] r_addr, n_addr, r_baddr, n_baddr;
    logic [2:0]  r_cnt, n_cnt, r_nbytes, n_nbytes;
    logic [31:0] r_st, n_st, r_ld, n_ld;
    logic        r_qneg, n_qneg, r_rneg, n_rneg;
    logic [12:0] r_text_used, r_data_used;
    logic [13:0] r_stack_used;

    logic [31:0] rd_a, rd_b;
    mie_pkg::t_gpr_wr gpr_wr;
    logic        div_start, div_done;
    logic [31:0] div_num, div_den, div_q, div_r;
    logic        text_we, data_we, stack_we;
    logic [7:0]  text_rd, data_rd, stack_rd, mem_rd;
    logic [31:0] txt_off, dat_off, stk_off;
    logic [31:0] text_bound, data_bound, stack_bound;
    logic        txt_ok, dat_ok, stk_ok;
    logic        is_load, is_store, mem_go;
    mie_pkg::t_action act;

    assign act = mie_pkg::t_action'(r_item.action);

    mie_regfile u_regfile (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ra    (i_in_data.src_reg),
        .i_rb    (i_in_data.tgt_reg),
        .i_wr    (gpr_wr),
        .o_da    (rd_a),
        .o_db    (rd_b)
    );

    mie_divider u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_num),
        .i_divisor   (div_den),
        .o_done      (div_done),
        .o_quotient  (div_q),
        .o_remainder (div_r)
    );

    // per-byte address map
    assign text_bound  = (32'(r_text_used) < 32'(mie_pkg::TEXT_DEPTH))
                         ? 32'(r_text_used) : 32'(mie_pkg::TEXT_DEPTH);
    assign data_bound  = (32'(r_data_used) < 32'(mie_pkg::DATA_DEPTH))
                         ? 32'(r_data_used) : 32'(mie_pkg::DATA_DEPTH);
    assign stack_bound = (32'(r_stack_used) < 32'(mie_pkg::STACK_DEPTH))
                         ? 32'(r_stack_used) : 32'(mie_pkg::STACK_DEPTH);
    assign txt_off = r_baddr - mie_pkg::TEXT_BASE;
    assign dat_off = r_baddr - mie_pkg::DATA_BASE;
    assign stk_off = mie_pkg::STACK_TOP - r_baddr;
    assign txt_ok  = txt_off < text_bound;
    assign dat_ok  = dat_off < data_bound;
    assign stk_ok  = (r_baddr <= mie_pkg::STACK_TOP) && (stk_off < stack_bound);

    assign is_load  = (act == mie_pkg::A_LB) || (act == mie_pkg::A_LBU) ||
                      (act == mie_pkg::A_LH) || (act == mie_pkg::A_LHU) ||
                      (act == mie_pkg::A_LW);
    assign is_store = (act == mie_pkg::A_SB) || (act == mie_pkg::A_SH) ||
                      (act == mie_pkg::A_SW) || (act == mie_pkg::A_PRELOAD);
    assign mem_go   = (r_state == mie_pkg::S_MEM) && is_store && (r_cnt != r_nbytes);
    assign text_we  = mem_go && (r_seg == mie_pkg::SEG_TEXT);
    assign data_we  = mem_go && (r_seg == mie_pkg::SEG_DATA);
    assign stack_we = mem_go && (r_seg == mie_pkg::SEG_STACK);

    mie_byte_ram #(.DEPTH(mie_pkg::TEXT_DEPTH)) u_text_ram (
        .i_clk   (i_clk),
        .i_we    (text_we),
        .i_addr  (txt_off[mie_pkg::TEXT_AW-1:0]),
        .i_wdata (r_st[31:24]),
        .o_rdata (text_rd)
    );

    mie_byte_ram #(.DEPTH(mie_pkg::DATA_DEPTH)) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (data_we),
        .i_addr  (dat_off[mie_pkg::DATA_AW-1:0]),
        .i_wdata (r_st[31:24]),
        .o_rdata (data_rd)
    );

    mie_byte_ram #(.DEPTH(mie_pkg::STACK_DEPTH)) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stack_we),
        .i_addr  (stk_off[mie_pkg::STACK_AW-1:0]),
        .i_wdata (r_st[31:24]),
        .o_rdata (stack_rd)
    );

    always_comb begin
        unique case (r_seg)
            mie_pkg::SEG_TEXT:  mem_rd = text_rd;
            mie_pkg::SEG_DATA:  mem_rd = data_rd;
            mie_pkg::SEG_STACK: mem_rd = stack_rd;
            default:            mem_rd = stack_rd;
        endcase
    end

    assign o_in_ready  = (r_state == mie_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= mie_pkg::S_IDLE;
            r_out_valid  <= 1'b0;
            r_hi         <= '0;
            r_lo         <= '0;
            r_pc         <= mie_pkg::TEXT_BASE;
            r_text_used  <= 13'(mie_pkg::TEXT_DEPTH);
            r_data_used  <= 13'(mie_pkg::DATA_DEPTH);
            r_stack_used <= 14'(mie_pkg::STACK_DEPTH);
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_hi        <= n_hi;
            r_lo        <= n_lo;
            r_pc        <= n_pc;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    mie_pkg::CFG_TEXT:  r_text_used  <= i_cfg_wdata[12:0];
                    mie_pkg::CFG_DATA:  r_data_used  <= i_cfg_wdata[12:0];
                    mie_pkg::CFG_STACK: r_stack_used <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_out    <= n_out;
        r_seg    <= n_seg;
        r_a      <= n_a;
        r_b      <= n_b;
        r_status <= n_status;
        r_wr     <= n_wr;
        r_widx   <= n_widx;
        r_wval   <= n_wval;
        r_next   <= n_next;
        r_prod   <= n_prod;
        r_addr   <= n_addr;
        r_baddr  <= n_baddr;
        r_cnt    <= n_cnt;
        r_nbytes <= n_nbytes;
        r_st     <= n_st;
        r_ld     <= n_ld;
        r_qneg   <= n_qneg;
        r_rneg   <= n_rneg;
    end

    always_comb begin
        logic [31:0] simm, zimm, pc4, sum_ab, sum_ai, dif, word, hcorr, mag_a, mag_b;
        simm   = {{16{r_item.immediate[15]}}, r_item.immediate};
        zimm   = {16'b0, r_item.immediate};
        pc4    = r_pc + 32'd4;
        sum_ab = rd_a + rd_b;
        sum_ai = rd_a + simm;
        dif    = rd_a - rd_b;
        word   = {r_ld[23:0], mem_rd};
        hcorr  = ((act == mie_pkg::A_MULT) && r_a[31]) ? r_b : '0;
        mag_a  = rd_a[31] ? (32'd0 - rd_a) : rd_a;
        mag_b  = rd_b[31] ? (32'd0 - rd_b) : rd_b;

        n_state     = r_state;
        n_item      = r_item;
        n_out       = r_out;
        n_seg       = r_seg;
        n_out_valid = r_out_valid;
        n_a         = r_a;
        n_b         = r_b;
        n_status    = r_status;
        n_wr        = r_wr;
        n_widx      = r_widx;
        n_wval      = r_wval;
        n_hi        = r_hi;
        n_lo        = r_lo;
        n_pc        = r_pc;
        n_next      = r_next;
        n_prod      = r_prod;
        n_addr      = r_addr;
        n_baddr     = r_baddr;
        n_cnt       = r_cnt;
        n_nbytes    = r_nbytes;
        n_st        = r_st;
        n_ld        = r_ld;
        n_qneg      = r_qneg;
        n_rneg      = r_rneg;
        gpr_wr      = '0;
        div_start   = 1'b0;
        div_num     = mag_a;
        div_den     = mag_b;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            mie_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_data;
                    n_state = mie_pkg::S_OPER;
                end
            end
            mie_pkg::S_OPER: begin
                n_a      = rd_a;
                n_b      = rd_b;
                n_status = mie_pkg::ST_OK;
                n_wr     = 1'b0;
                n_widx   = r_item.dst_reg;
                n_wval   = '0;
                n_next   = pc4;
                n_cnt    = '0;
                n_state  = mie_pkg::S_DONE;
                unique case (act)
                    mie_pkg::A_ADD: begin
                        n_wr   = 1'b1;
                        n_wval = sum_ab;
                        if (((rd_a ^ sum_ab) & (rd_b ^ sum_ab)) >> 31 != 0) begin
                            n_status = mie_pkg::ST_OVF;
                        end
                    end
                    mie_pkg::A_ADDI: begin
                        n_wr   = 1'b1;
                        n_widx = r_item.tgt_reg;
                        n_wval = sum_ai;
                        if (((rd_a ^ sum_ai) & (simm ^ sum_ai)) >> 31 != 0) begin
                            n_status = mie_pkg::ST_OVF;
                        end
                    end
                    mie_pkg::A_ADDIU: begin
                        n_wr = 1'b1; n_widx = r_item.tgt_reg; n_wval = sum_ai;
                    end
                    mie_pkg::A_ADDU: begin
                        n_wr = 1'b1; n_wval = sum_ab;
                    end
                    mie_pkg::A_AND: begin
                        n_wr = 1'b1; n_wval = rd_a & rd_b;
                    end
                    mie_pkg::A_ANDI: begin
                        n_wr = 1'b1; n_widx = r_item.tgt_reg; n_wval = rd_a & zimm;
                    end
                    mie_pkg::A_BEQ: begin
                        if (rd_a == rd_b) n_next = pc4 + {simm[29:0], 2'b00};
                    end
                    mie_pkg::A_BNE: begin
                        if (rd_a != rd_b) n_next = pc4 + {simm[29:0], 2'b00};
                    end
                    mie_pkg::A_DIV, mie_pkg::A_DIVU: begin
                        if (rd_b == '0) begin
                            n_status = mie_pkg::ST_DIVZ;
                        end else begin
                            div_start = 1'b1;
                            if (act == mie_pkg::A_DIVU) begin
                                div_num = rd_a;
                                div_den = rd_b;
                                n_qneg  = 1'b0;
                                n_rneg  = 1'b0;
                            end else begin
                                n_qneg = rd_a[31] ^ rd_b[31];
                                n_rneg = rd_a[31];
                            end
                            n_state = mie_pkg::S_DIV;
                        end
                    end
                    mie_pkg::A_J: begin
                        n_next   = {pc4[31:28], r_item.jump_target, 2'b00};
                        n_status = mie_pkg::ST_JUMP;
                    end
                    mie_pkg::A_JAL: begin
                        n_wr     = 1'b1;
                        n_widx   = 5'd31;
                        n_wval   = pc4;
                        n_next   = {pc4[31:28], r_item.jump_target, 2'b00};
                        n_status = mie_pkg::ST_JUMP;
                    end
                    mie_pkg::A_JALR: begin
                        n_wr     = 1'b1;
                        n_wval   = pc4;
                        n_next   = rd_a;
                        n_status = mie_pkg::ST_JUMP;
                    end
                    mie_pkg::A_JR: begin
                        n_next   = rd_a;
                        n_status = mie_pkg::ST_JUMP;
                    end
                    mie_pkg::A_LB, mie_pkg::A_LBU, mie_pkg::A_SB: begin
                        n_addr = sum_ai; n_baddr = sum_ai; n_nbytes = 3'd1;
                        n_widx = r_item.tgt_reg; n_st = {rd_b[7:0], 24'b0};
                        n_state = mie_pkg::S_MAP;
                    end
                    mie_pkg::A_LH, mie_pkg::A_LHU, mie_pkg::A_SH: begin
                        n_addr = sum_ai; n_baddr = sum_ai; n_nbytes = 3'd2;
                        n_widx = r_item.tgt_reg; n_st = {rd_b[15:0], 16'b0};
                        n_state = mie_pkg::S_MAP;
                    end
                    mie_pkg::A_LW, mie_pkg::A_SW: begin
                        n_addr = sum_ai; n_baddr = sum_ai; n_nbytes = 3'd4;
                        n_widx = r_item.tgt_reg; n_st = rd_b;
                        n_state = mie_pkg::S_MAP;
                    end
                    mie_pkg::A_PRELOAD: begin
                        n_addr   = r_item.preload_address;
                        n_baddr  = r_item.preload_address;
                        n_nbytes = 3'd1;
                        n_st     = {r_item.preload_value, 24'b0};
                        n_next   = r_pc;
                        n_state  = mie_pkg::S_MAP;
                    end
                    mie_pkg::A_LUI: begin
                        n_wr = 1'b1; n_widx = r_item.tgt_reg; n_wval = {zimm[15:0], 16'b0};
                    end
                    mie_pkg::A_MFHI: begin
                        n_wr = 1'b1; n_wval = r_hi;
                    end
                    mie_pkg::A_MTHI: n_hi = rd_a;
                    mie_pkg::A_MFLO: begin
                        n_wr = 1'b1; n_wval = r_lo;
                    end
                    mie_pkg::A_MTLO: n_lo = rd_a;
                    mie_pkg::A_MULT, mie_pkg::A_MULTU: begin
                        n_prod  = rd_a * rd_b;
                        n_state = mie_pkg::S_MUL;
                    end
                    mie_pkg::A_NOR: begin
                        n_wr = 1'b1; n_wval = ~(rd_a | rd_b);
                    end
                    mie_pkg::A_XOR: begin
                        n_wr = 1'b1; n_wval = rd_a ^ rd_b;
                    end
                    mie_pkg::A_OR: begin
                        n_wr = 1'b1; n_wval = rd_a | rd_b;
                    end
                    mie_pkg::A_ORI: begin
                        n_wr = 1'b1; n_widx = r_item.tgt_reg; n_wval = rd_a | zimm;
                    end
                    mie_pkg::A_SLT: begin
                        n_wr = 1'b1; n_wval = {31'b0, $signed(rd_a) < $signed(rd_b)};
                    end
                    mie_pkg::A_SLTI: begin
                        n_wr = 1'b1; n_widx = r_item.tgt_reg;
                        n_wval = {31'b0, $signed(rd_a) < $signed(simm)};
                    end
                    mie_pkg::A_SLTIU: begin
                        n_wr = 1'b1; n_widx = r_item.tgt_reg; n_wval = {31'b0, rd_a < simm};
                    end
                    mie_pkg::A_SLTU: begin
                        n_wr = 1'b1; n_wval = {31'b0, rd_a < rd_b};
                    end
                    mie_pkg::A_SLL: begin
                        n_wr = 1'b1; n_wval = rd_b << r_item.shift_amount;
                    end
                    mie_pkg::A_SLLV: begin
                        n_wr = 1'b1; n_wval = rd_b << rd_a[4:0];
                    end
                    mie_pkg::A_SRL: begin
                        n_wr = 1'b1; n_wval = rd_b >> r_item.shift_amount;
                    end
                    mie_pkg::A_SRLV: begin
                        n_wr = 1'b1; n_wval = rd_b >> rd_a[4:0];
                    end
                    mie_pkg::A_SRA: begin
                        n_wr = 1'b1; n_wval = $signed(rd_b) >>> r_item.shift_amount;
                    end
                    mie_pkg::A_SRAV: begin
                        n_wr = 1'b1; n_wval = $signed(rd_b) >>> rd_a[4:0];
                    end
                    mie_pkg::A_SUB: begin
                        n_wr   = 1'b1;
                        n_wval = dif;
                        if (((rd_a ^ rd_b) & (rd_a ^ dif)) >> 31 != 0) begin
                            n_status = mie_pkg::ST_OVF;
                        end
                    end
                    mie_pkg::A_SUBU: begin
                        n_wr = 1'b1; n_wval = dif;
                    end
                    default: n_next = r_pc;
                endcase
            end
            mie_pkg::S_MUL: begin
                // signed product from the unsigned one: subtract cross terms from hi
                n_lo = r_prod[31:0];
                n_hi = r_prod[63:32] - hcorr -
                       (((act == mie_pkg::A_MULT) && r_b[31]) ? r_a : 32'd0);
                n_state = mie_pkg::S_DONE;
            end
            mie_pkg::S_DIV: begin
                if (div_done) begin
                    n_lo    = r_qneg ? (32'd0 - div_q) : div_q;
                    n_hi    = r_rneg ? (32'd0 - div_r) : div_r;
                    n_state = mie_pkg::S_DONE;
                end
            end
            mie_pkg::S_MAP: begin
                if (!(txt_ok || dat_ok || stk_ok)) begin
                    n_status = mie_pkg::ST_MEM;
                    n_state  = mie_pkg::S_DONE;
                end else begin
                    if (r_cnt == '0) begin
                        n_seg = txt_ok ? mie_pkg::SEG_TEXT :
                                (dat_ok ? mie_pkg::SEG_DATA : mie_pkg::SEG_STACK);
                    end
                    if (r_cnt == r_nbytes - 3'd1) begin
                        n_cnt   = '0;
                        n_baddr = r_addr;
                        n_state = mie_pkg::S_MEM;
                    end else begin
                        n_cnt   = r_cnt + 3'd1;
                        n_baddr = r_baddr + 32'd1;
                    end
                end
            end
            mie_pkg::S_MEM: begin
                // byte k is requested at count k and arrives at count k+1
                if (r_cnt != '0) begin
                    n_ld = word;
                end
                if (r_cnt == r_nbytes) begin
                    if (is_load) begin
                        n_wr = 1'b1;
                        priority case (act)
                            mie_pkg::A_LB:  n_wval = {{24{word[7]}}, word[7:0]};
                            mie_pkg::A_LBU: n_wval = {24'b0, word[7:0]};
                            mie_pkg::A_LH:  n_wval = {{16{word[15]}}, word[15:0]};
                            mie_pkg::A_LHU: n_wval = {16'b0, word[15:0]};
                            default:        n_wval = word;
                        endcase
                    end
                    n_state = mie_pkg::S_DONE;
                end else begin
                    n_st    = {r_st[23:0], 8'b0};
                    n_baddr = r_baddr + 32'd1;
                    n_cnt   = r_cnt + 3'd1;
                end
            end
            mie_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    gpr_wr.we   = r_wr && (r_widx != '0);
                    gpr_wr.idx  = r_widx;
                    gpr_wr.data = r_wval;
                    n_out.status        = r_status;
                    n_out.reg_written   = gpr_wr.we;
                    n_out.written_index = gpr_wr.we ? r_widx : 5'd0;
                    n_out.written_value = gpr_wr.we ? r_wval : 32'd0;
                    n_out.hi_now        = r_hi;
                    n_out.lo_now        = r_lo;
                    n_out.pc_now        = r_next;
                    n_out_valid = 1'b1;
                    n_pc        = r_next;
                    n_state     = mie_pkg::S_IDLE;
                end
            end
            default: n_state = mie_pkg::S_IDLE;
        endcase
    end

    a_accept_to_oper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == mie_pkg::S_OPER))
        else $error("accepted transaction did not enter operand stage");

    a_mem_write_in_mem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (text_we || data_we || stack_we) |-> (r_state == mie_pkg::S_MEM))
        else $error("byte memory written outside memory stage");

    a_no_write_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.reg_written) |->
        (o_out_data.written_index == 5'd0 && o_out_data.written_value == 32'sd0))
        else $error("unwritten register result carries nonzero fields");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == mie_pkg::S_DIV))
        else $error("divider finished outside divide state");

endmodule
`default_nettype wire

FILE: dv/tb.sv
// tb: self-checking testbench for mips_integer_execute_unit_top, directed rows then random
// instruction streams checked against an in-bench execute predictor; depends on mie_pkg
`default_nettype none
module tb;
    import mie_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 60;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    in_valid = 1'b0;
    logic    in_ready;
    t_in     in_data = '0;
    logic    out_valid;
    logic    out_ready = 1'b0;
    t_out    out_data;
    logic    cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    always #5 i_clk = ~i_clk;

    mips_integer_execute_unit_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_wdata(cfg_wdata)
    );

    // architectural state mirrored by the predictor
    logic [31:0] gpr[32];
    logic [31:0] hi_r, lo_r, pc_r;
    int          seg_used[3];
    int          seg_depth[3] = '{TEXT_DEPTH, DATA_DEPTH, STACK_DEPTH};
    logic [7:0]  mem_byte[3][STACK_DEPTH];
    bit          mem_set[3][STACK_DEPTH];

    t_out        pending_results[$];
    int          errs = 0;
    int          cycles = 0;
    int          issued = 0;
    bit          calm_in = 1'b0;

    typedef struct {
        t_in  x;
        bit   typed;
        t_out want;
    } t_row;
    t_row stim_rows[$];

    function automatic int seg_bound(int s);
        return seg_used[s] < seg_depth[s] ? seg_used[s] : seg_depth[s];
    endfunction

    function automatic bit locate(input logic [31:0] a, output int sg, output int ix);
        if (a >= TEXT_BASE && longint'(a - TEXT_BASE) < seg_bound(0)) begin
            sg = 0; ix = a - TEXT_BASE; return 1'b1;
        end
        if (a >= DATA_BASE && longint'(a - DATA_BASE) < seg_bound(1)) begin
            sg = 1; ix = a - DATA_BASE; return 1'b1;
        end
        if (a <= STACK_TOP && longint'(STACK_TOP - a) < seg_bound(2)) begin
            sg = 2; ix = STACK_TOP - a; return 1'b1;
        end
        sg = 0; ix = 0;
        return 1'b0;
    endfunction

    function automatic bit map_span(input logic [31:0] a, input int n,
                                    output int sg[4], output int ix[4]);
        for (int k = 0; k < n; k++)
            if (!locate(a + 32'(k), sg[k], ix[k])) return 1'b0;
        return 1'b1;
    endfunction

    function automatic int access_bytes(logic [5:0] act);
        case (act)
            A_LB, A_LBU, A_SB: return 1;
            A_LH, A_LHU, A_SH: return 2;
            A_LW, A_SW:        return 4;
            default:           return 0;
        endcase
    endfunction

    function automatic void set_gpr(input logic [4:0] idx, input logic [31:0] v,
                                    inout t_out o);
        if (idx == 0) return;
        gpr[idx] = v;
        o.reg_written = 1'b1;
        o.written_index = idx;
        o.written_value = v;
    endfunction

    // loads that would touch never-written bytes become stores of the same width
    function automatic t_in avoid_unwritten(t_in x);
        int sg[4], ix[4];
        int n;
        logic [31:0] addr;
        n = access_bytes(x.action);
        addr = gpr[x.src_reg] + {{16{x.immediate[15]}}, x.immediate};
        if (n == 0 || x.action inside {A_SB, A_SH, A_SW}) return x;
        if (!map_span(addr, n, sg, ix)) return x;
        for (int k = 0; k < n; k++)
            if (!mem_set[sg[k]][ix[k]])
                x.action = (n == 1) ? A_SB : (n == 2) ? A_SH : A_SW;
        return x;
    endfunction

    function automatic t_out execute(t_in x);
        logic [31:0] a, b, r, simm, zimm, pc4, nxt, addr, ma, mb, q, m;
        logic [63:0] p;
        t_out o;
        int sg[4], ix[4];
        int n;
        a = gpr[x.src_reg];
        b = gpr[x.tgt_reg];
        zimm = {16'b0, x.immediate};
        simm = {{16{x.immediate[15]}}, x.immediate};
        pc4 = pc_r + 32'd4;
        addr = a + simm;
        nxt = pc4;
        o = '0;
        n = access_bytes(x.action);
        case (x.action)
            A_ADD: begin
                r = a + b;
                if (((a ^ r) & (b ^ r)) >> 31) o.status = ST_OVF;
                set_gpr(x.dst_reg, r, o);
            end
            A_ADDI: begin
                r = a + simm;
                if (((a ^ r) & (simm ^ r)) >> 31) o.status = ST_OVF;
                set_gpr(x.tgt_reg, r, o);
            end
            A_ADDIU: set_gpr(x.tgt_reg, a + simm, o);
            A_ADDU:  set_gpr(x.dst_reg, a + b, o);
            A_AND:   set_gpr(x.dst_reg, a & b, o);
            A_ANDI:  set_gpr(x.tgt_reg, a & zimm, o);
            A_BEQ:   if (a == b) nxt = pc4 + (simm << 2);
            A_BNE:   if (a != b) nxt = pc4 + (simm << 2);
            A_DIV: begin
                if (b == 0) o.status = ST_DIVZ;
                else begin
                    ma = a[31] ? -a : a;
                    mb = b[31] ? -b : b;
                    q = ma / mb;
                    m = ma % mb;
                    if (a[31] ^ b[31]) q = -q;
                    if (a[31]) m = -m;
                    lo_r = q;
                    hi_r = m;
                end
            end
            A_DIVU: begin
                if (b == 0) o.status = ST_DIVZ;
                else begin
                    lo_r = a / b;
                    hi_r = a % b;
                end
            end
            A_J: begin
                nxt = {pc4[31:28], x.jump_target, 2'b00};
                o.status = ST_JUMP;
            end
            A_JAL: begin
                set_gpr(5'd31, pc4, o);
                nxt = {pc4[31:28], x.jump_target, 2'b00};
                o.status = ST_JUMP;
            end
            A_JALR: begin
                set_gpr(x.dst_reg, pc4, o);
                nxt = a;
                o.status = ST_JUMP;
            end
            A_JR: begin
                nxt = a;
                o.status = ST_JUMP;
            end
            A_LB, A_LBU, A_LH, A_LHU, A_LW: begin
                if (!map_span(addr, n, sg, ix)) o.status = ST_MEM;
                else begin
                    r = '0;
                    for (int k = 0; k < n; k++) r = (r << 8) | mem_byte[sg[k]][ix[k]];
                    if (x.action == A_LB) r = {{24{r[7]}}, r[7:0]};
                    if (x.action == A_LH) r = {{16{r[15]}}, r[15:0]};
                    set_gpr(x.tgt_reg, r, o);
                end
            end
            A_SB, A_SH, A_SW: begin
                if (!map_span(addr, n, sg, ix)) o.status = ST_MEM;
                else begin
                    for (int k = 0; k < n; k++) begin
                        mem_byte[sg[k]][ix[k]] = b >> (8 * (n - 1 - k));
                        mem_set[sg[k]][ix[k]] = 1'b1;
                    end
                end
            end
            A_LUI:   set_gpr(x.tgt_reg, zimm << 16, o);
            A_MFHI:  set_gpr(x.dst_reg, hi_r, o);
            A_MTHI:  hi_r = a;
            A_MFLO:  set_gpr(x.dst_reg, lo_r, o);
            A_MTLO:  lo_r = a;
            A_MULT, A_MULTU: begin
                if (x.action == A_MULT) p = 64'($signed(a)) * 64'($signed(b));
                else p = {32'b0, a} * {32'b0, b};
                hi_r = p[63:32];
                lo_r = p[31:0];
            end
            A_NOR:   set_gpr(x.dst_reg, ~(a | b), o);
            A_XOR:   set_gpr(x.dst_reg, a ^ b, o);
            A_OR:    set_gpr(x.dst_reg, a | b, o);
            A_ORI:   set_gpr(x.tgt_reg, a | zimm, o);
            A_SLT:   set_gpr(x.dst_reg, {31'b0, $signed(a) < $signed(b)}, o);
            A_SLTI:  set_gpr(x.tgt_reg, {31'b0, $signed(a) < $signed(simm)}, o);
            A_SLTIU: set_gpr(x.tgt_reg, {31'b0, a < simm}, o);
            A_SLTU:  set_gpr(x.dst_reg, {31'b0, a < b}, o);
            A_SLL:   set_gpr(x.dst_reg, b << x.shift_amount, o);
            A_SLLV:  set_gpr(x.dst_reg, b << a[4:0], o);
            A_SRL:   set_gpr(x.dst_reg, b >> x.shift_amount, o);
            A_SRLV:  set_gpr(x.dst_reg, b >> a[4:0], o);
            A_SRA:   set_gpr(x.dst_reg, $signed(b) >>> x.shift_amount, o);
            A_SRAV:  set_gpr(x.dst_reg, $signed(b) >>> a[4:0], o);
            A_SUB: begin
                r = a - b;
                if (((a ^ b) & (a ^ r)) >> 31) o.status = ST_OVF;
                set_gpr(x.dst_reg, r, o);
            end
            A_SUBU:  set_gpr(x.dst_reg, a - b, o);
            A_PRELOAD: begin
                nxt = pc_r;
                if (!locate(x.preload_address, sg[0], ix[0])) o.status = ST_MEM;
                else begin
                    mem_byte[sg[0]][ix[0]] = x.preload_value;
                    mem_set[sg[0]][ix[0]] = 1'b1;
                end
            end
            default: nxt = pc_r;
        endcase
        pc_r = nxt;
        o.hi_now = hi_r;
        o.lo_now = lo_r;
        o.pc_now = pc_r;
        return o;
    endfunction

    function automatic t_in instr(t_action act, int s, int t, int d, int sh, int imm);
        t_in x;
        x = '0;
        x.action = act;
        x.src_reg = s;
        x.tgt_reg = t;
        x.dst_reg = d;
        x.shift_amount = sh;
        x.immediate = imm;
        return x;
    endfunction

    function automatic void add_row(t_in x, bit typed = 1'b0, t_out want = '0);
        t_row rw;
        rw.x = x;
        rw.typed = typed;
        rw.want = want;
        stim_rows.push_back(rw);
    endfunction

    // predict, queue the expectation, then hold valid until the transaction is taken
    task automatic issue(t_in x, bit typed = 1'b0, t_out want = '0);
        t_out e;
        int gap;
        x = avoid_unwritten(x);
        e = execute(x);
        pending_results.push_back(typed ? want : e);
        issued++;
        in_valid <= 1'b1;
        in_data <= x;
        do @(posedge i_clk); while (!in_ready);
        if ($urandom_range(0, 59) == 0) calm_in = !calm_in;
        gap = calm_in ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_bounds(int text_b, int data_b, int stack_b);
        int vals[3];
        vals = '{text_b, data_b, stack_b};
        drain();
        for (int i = 0; i < 3; i++) begin
            cfg_we <= 1'b1;
            cfg_index <= i;
            cfg_wdata <= vals[i];
            seg_used[i] = vals[i] & (i == CFG_STACK ? 16'h3fff : 16'h1fff);
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_addr();
        int s, b, off;
        s = $urandom_range(0, 2);
        b = seg_bound(s);
        case ($urandom_range(0, 3))
            0: off = $urandom_range(0, b + 3);
            1: off = b - int'($urandom_range(1, 4));
            2: off = -int'($urandom_range(1, 3));
            default: off = $urandom_range(0, 7);
        endcase
        if (s == 2) return STACK_TOP - 32'(off);
        return (s == 0 ? TEXT_BASE : DATA_BASE) + 32'(off);
    endfunction

    task automatic load_reg(int r, logic [31:0] v);
        issue(instr(A_LUI, 0, r, 0, 0, int'($signed(v[31:16]))));
        issue(instr(A_ORI, r, r, 0, 0, int'($signed(v[15:0]))));
    endtask

    task automatic random_items(int count);
        t_in x;
        logic [31:0] a, v;
        int rb, sel, imm;
        int stop_at;
        logic [31:0] odd_vals[5] = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 0, 1};
        stop_at = issued + count;
        while (issued < stop_at) begin
            sel = $urandom_range(0, 99);
            if (sel < 35) begin
                // base register set up, store, then a load of the same place
                a = pick_addr();
                imm = $urandom_range(0, 3) == 0 ? int'($signed(16'($urandom)))
                                                : int'($urandom_range(0, 128)) - 64;
                rb = $urandom_range(1, 31);
                load_reg(rb, a - 32'(imm));
                x = instr(A_SB, rb, $urandom_range(0, 31), 0, 0, imm);
                x.action = A_SB + $urandom_range(0, 2);
                issue(x);
                x = instr(A_LB, rb, $urandom_range(0, 31), 0, 0, imm);
                case ($urandom_range(0, 4))
                    0: x.action = A_LB;
                    1: x.action = A_LBU;
                    2: x.action = A_LH;
                    3: x.action = A_LHU;
                    default: x.action = A_LW;
                endcase
                issue(x);
            end else if (sel < 45) begin
                x = instr(A_PRELOAD, 0, 0, 0, 0, 0);
                x.preload_address = $urandom_range(0, 4) == 0 ? $urandom : pick_addr();
                x.preload_value = $urandom;
                issue(x);
            end else if (sel < 58) begin
                v = $urandom_range(0, 1) ? odd_vals[$urandom_range(0, 4)] : $urandom;
                load_reg($urandom_range(0, 31), v);
            end else begin
                x = {$urandom, $urandom, $urandom};
                x.action = $urandom_range(0, 9) == 0 ? $urandom_range(46, 63)
                                                     : $urandom_range(0, 45);
                issue(x);
            end
        end
    endtask

    // receiver: stall for a drawn number of cycles after each result
    int  out_stall = 0;
    bit  calm_out = 1'b0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            out_stall = 0;
        end else if (out_valid && out_ready) begin
            if ($urandom_range(0, 59) == 0) calm_out = !calm_out;
            out_stall = calm_out ? 0 : $urandom_range(0, 13);
            out_ready <= (out_stall == 0);
        end else if (out_stall > 0) begin
            out_stall--;
            out_ready <= (out_stall == 0);
        end else begin
            out_ready <= 1'b1;
        end
    end

    // result check against the oldest expected transaction
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                errs++;
                $error("unexpected result transaction");
            end else begin
                want = pending_results.pop_front();
                if (out_data.status !== want.status) begin
                    errs++;
                    $error("status expected %0d got %0d", want.status, out_data.status);
                end
                if (out_data.reg_written !== want.reg_written) begin
                    errs++;
                    $error("reg_written expected %0d got %0d", want.reg_written,
                           out_data.reg_written);
                end
                if (out_data.written_index !== want.written_index) begin
                    errs++;
                    $error("written_index expected %0d got %0d", want.written_index,
                           out_data.written_index);
                end
                if (out_data.written_value !== want.written_value) begin
                    errs++;
                    $error("written_value expected %h got %h", want.written_value,
                           out_data.written_value);
                end
                if (out_data.hi_now !== want.hi_now) begin
                    errs++;
                    $error("hi_now expected %h got %h", want.hi_now, out_data.hi_now);
                end
                if (out_data.lo_now !== want.lo_now) begin
                    errs++;
                    $error("lo_now expected %h got %h", want.lo_now, out_data.lo_now);
                end
                if (out_data.pc_now !== want.pc_now) begin
                    errs++;
                    $error("pc_now expected %h got %h", want.pc_now, out_data.pc_now);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        t_in x;
        for (int i = 0; i < 32; i++) gpr[i] = '0;
        hi_r = '0;
        lo_r = '0;
        pc_r = TEXT_BASE;
        seg_used = '{4096, 4096, 8192};

        // expectations right after reset are typed in
        add_row(instr(A_ADDI, 0, 1, 0, 0, -1), 1,
                '{ST_OK, 1'b1, 5'd1, 32'hffff_ffff, 32'h0, 32'h0, 32'h0040_0004});
        add_row(instr(A_LUI, 0, 2, 0, 0, -32768), 1,
                '{ST_OK, 1'b1, 5'd2, 32'h8000_0000, 32'h0, 32'h0, 32'h0040_0008});
        add_row(instr(A_ADD, 2, 1, 3, 0, 0), 1,
                '{ST_OVF, 1'b1, 5'd3, 32'h7fff_ffff, 32'h0, 32'h0, 32'h0040_000c});
        add_row(instr(A_DIV, 1, 0, 0, 0, 0), 1,
                '{ST_DIVZ, 1'b0, 5'd0, 32'h0, 32'h0, 32'h0, 32'h0040_0010});
        add_row(instr(A_LW, 0, 4, 0, 0, 0), 1,
                '{ST_MEM, 1'b0, 5'd0, 32'h0, 32'h0, 32'h0, 32'h0040_0014});
        add_row(instr(A_ADDU, 1, 1, 0, 0, 0), 1,
                '{ST_OK, 1'b0, 5'd0, 32'h0, 32'h0, 32'h0, 32'h0040_0018});
        add_row(instr(A_SUB, 3, 1, 8, 0, 0));
        add_row(instr(A_SUBU, 0, 1, 9, 0, 0));
        add_row(instr(A_ADDIU, 3, 10, 0, 0, 32767));
        add_row(instr(A_ANDI, 1, 10, 0, 0, -1));
        add_row(instr(A_AND, 1, 2, 11, 0, 0));
        add_row(instr(A_OR, 2, 3, 11, 0, 0));
        add_row(instr(A_ORI, 0, 11, 0, 0, -32768));
        add_row(instr(A_XOR, 1, 3, 12, 0, 0));
        add_row(instr(A_NOR, 0, 0, 12, 0, 0));
        add_row(instr(A_SLT, 2, 1, 13, 0, 0));
        add_row(instr(A_SLTU, 2, 1, 13, 0, 0));
        add_row(instr(A_SLTI, 1, 14, 0, 0, 0));
        add_row(instr(A_SLTIU, 3, 14, 0, 0, -1));
        add_row(instr(A_SLL, 0, 1, 15, 31, 0));
        add_row(instr(A_SLLV, 1, 3, 15, 0, 0));
        add_row(instr(A_SRL, 0, 1, 16, 31, 0));
        add_row(instr(A_SRLV, 2, 1, 16, 0, 0));
        add_row(instr(A_SRA, 0, 2, 17, 31, 0));
        add_row(instr(A_SRAV, 1, 2, 17, 0, 0));
        add_row(instr(A_MULT, 2, 1, 0, 0, 0));
        add_row(instr(A_MULTU, 1, 1, 0, 0, 0));
        add_row(instr(A_DIV, 2, 1, 0, 0, 0));
        add_row(instr(A_DIVU, 1, 3, 0, 0, 0));
        add_row(instr(A_MFHI, 0, 0, 18, 0, 0));
        add_row(instr(A_MFLO, 0, 0, 19, 0, 0));
        add_row(instr(A_MTHI, 3, 0, 0, 0, 0));
        add_row(instr(A_MTLO, 2, 0, 0, 0, 0));
        add_row(instr(A_LUI, 0, 5, 0, 0, 16'h1000));
        x = instr(A_PRELOAD, 0, 0, 0, 0, 0);
        x.preload_address = DATA_BASE;
        x.preload_value = 8'h80;
        add_row(x);
        add_row(instr(A_LB, 5, 6, 0, 0, 0));
        add_row(instr(A_SW, 5, 1, 0, 0, 4));
        add_row(instr(A_LHU, 5, 7, 0, 0, 6));
        add_row(instr(A_SH, 5, 2, 0, 0, 8));
        add_row(instr(A_LH, 5, 7, 0, 0, 8));
        add_row(instr(A_SB, 5, 1, 0, 0, 10));
        add_row(instr(A_LBU, 5, 7, 0, 0, 10));
        add_row(instr(A_LW, 5, 7, 0, 0, 4));
        x = instr(A_PRELOAD, 0, 0, 0, 0, 0);
        x.preload_address = STACK_TOP;
        x.preload_value = 8'hff;
        add_row(x);
        add_row(instr(A_LBU, 3, 20, 0, 0, 0));
        add_row(instr(A_LH, 3, 20, 0, 0, 0));
        add_row(instr(A_BEQ, 0, 0, 0, 0, -8));
        add_row(instr(A_BNE, 1, 0, 0, 0, 32767));
        x = instr(A_J, 0, 0, 0, 0, 0);
        x.jump_target = 26'h3ff_ffff;
        add_row(x);
        x = instr(A_JAL, 0, 0, 0, 0, 0);
        x.jump_target = 26'h010_0000;
        add_row(x);
        add_row(instr(A_JALR, 31, 0, 21, 0, 0));
        add_row(instr(A_JR, 21, 0, 0, 0, 0));
        x = '1;
        add_row(x);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_rows[i]) issue(stim_rows[i].x, stim_rows[i].typed, stim_rows[i].want);
        random_items(300);
        write_bounds(0, 0, 0);
        random_items(200);
        write_bounds(8191, 8191, 16383);
        random_items(300);
        write_bounds($urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(1, 16));
        random_items(250);
        write_bounds($urandom_range(0, 4096), $urandom_range(0, 4096),
                     $urandom_range(0, 8192));
        random_items(250);
        drain();

        if (errs == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
`default_nettype wire

FILE: mips_integer_execute_unit_top.f
hdl/mie_pkg.sv
hdl/mie_byte_ram.sv
hdl/mie_regfile.sv
hdl/mie_divider.sv
hdl/mips_integer_execute_unit_top.sv
dv/tb.sv
